// ===== rtl/core/spa_pkg.sv =====
// Shared constants and types for the sparse polynomial adder.
`default_nettype none

package spa_pkg;

    // Term list capacity (1 to 32)
    localparam int MAX_TERMS = 16;

    // Field widths
    localparam int EXP_W  = 16;
    localparam int COEF_W = 32;
    localparam int SUM_W  = COEF_W + 1;
    localparam int TERM_W = EXP_W + COEF_W;

    // Index and count widths
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    // Action codes
    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_MERGE  = 2'd2;

    // Control from top level to merge engine
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] cnt_a;
        logic [CNT_W-1:0] cnt_b;
    } spa_ctl_t;

    // Status from merge engine to top level
    typedef struct packed {
        logic busy;
        logic done;
    } spa_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/spa_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module spa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                          clk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                              wr_data,
    input  wire logic                                          re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered; data holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/spa_merge.sv =====
// Merge engine: walks both term memories and emits the sum terms.
`default_nettype none

module spa_merge (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire spa_pkg::spa_ctl_t             ctl,
    output spa_pkg::spa_sts_t                  sts,
    output logic                               rd_en,
    output logic [spa_pkg::IDX_W-1:0]          rd_addr_a,
    output logic [spa_pkg::IDX_W-1:0]          rd_addr_b,
    input  wire logic [spa_pkg::TERM_W-1:0]    rd_data_a,
    input  wire logic [spa_pkg::TERM_W-1:0]    rd_data_b,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [spa_pkg::EXP_W-1:0]          term_exponent,
    output logic signed [spa_pkg::SUM_W-1:0]   term_coefficient,
    output logic                               result_empty,
    output logic                               last_term
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_EV   = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [spa_pkg::CNT_W-1:0]       p_reg, p_next;
    logic [spa_pkg::CNT_W-1:0]       q_reg, q_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [spa_pkg::EXP_W-1:0]       pend_exp_reg, pend_exp_next;
    logic signed [spa_pkg::SUM_W-1:0] pend_coef_reg, pend_coef_next;
    logic                            out_valid_reg, out_valid_next;
    logic [spa_pkg::EXP_W-1:0]       out_exp_reg, out_exp_next;
    logic signed [spa_pkg::SUM_W-1:0] out_coef_reg, out_coef_next;
    logic                            out_empty_reg, out_empty_next;
    logic                            out_last_reg, out_last_next;

    logic                            out_free;
    logic                            out_load;
    logic                            a_ok, b_ok;
    logic [spa_pkg::EXP_W-1:0]       exp_a, exp_b;
    logic signed [spa_pkg::SUM_W-1:0] coef_a, coef_b, coef_sum;
    logic                            take_a, take_b, take_both;
    logic                            new_vld;
    logic [spa_pkg::EXP_W-1:0]       new_exp;
    logic signed [spa_pkg::SUM_W-1:0] new_coef;

    // Unpack read data, sign-extend coefficients
    assign exp_a  = rd_data_a[spa_pkg::TERM_W-1 -: spa_pkg::EXP_W];
    assign exp_b  = rd_data_b[spa_pkg::TERM_W-1 -: spa_pkg::EXP_W];
    assign coef_a = {rd_data_a[spa_pkg::COEF_W-1], rd_data_a[spa_pkg::COEF_W-1:0]};
    assign coef_b = {rd_data_b[spa_pkg::COEF_W-1], rd_data_b[spa_pkg::COEF_W-1:0]};
    assign coef_sum = coef_a + coef_b;

    // Pick the next term from the heads of both lists
    assign a_ok      = (p_reg < ctl.cnt_a);
    assign b_ok      = (q_reg < ctl.cnt_b);
    assign take_both = a_ok && b_ok && (exp_a == exp_b);
    assign take_a    = a_ok && (!b_ok || (exp_a > exp_b));
    assign take_b    = b_ok && (!a_ok || (exp_b > exp_a));
    assign new_vld   = take_a || take_b || (take_both && (coef_sum != '0));
    assign new_exp   = take_b ? exp_b : exp_a;
    assign new_coef  = take_a ? coef_a : (take_b ? coef_b : coef_sum);

    assign out_free  = !out_valid_reg || !out_stall;

    assign rd_addr_a = p_reg[spa_pkg::IDX_W-1:0];
    assign rd_addr_b = q_reg[spa_pkg::IDX_W-1:0];

    // Sequencer: read heads, evaluate, hold one term back to mark the last
    always_comb
    begin
        state_next      = state_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        pend_valid_next = pend_valid_reg;
        pend_exp_next   = pend_exp_reg;
        pend_coef_next  = pend_coef_reg;
        out_exp_next    = out_exp_reg;
        out_coef_next   = out_coef_reg;
        out_empty_next  = out_empty_reg;
        out_last_next   = out_last_reg;
        out_load        = 1'b0;
        rd_en           = 1'b0;
        sts.busy        = (state_reg != ST_IDLE);
        sts.done        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    p_next     = '0;
                    q_next     = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (a_ok || b_ok)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_EV;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_EV:
            begin
                if (!(new_vld && pend_valid_reg && !out_free))
                begin
                    if (new_vld)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load       = 1'b1;
                            out_exp_next   = pend_exp_reg;
                            out_coef_next  = pend_coef_reg;
                            out_empty_next = 1'b0;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_exp_next   = new_exp;
                        pend_coef_next  = new_coef;
                    end
                    if (take_a || take_both)
                    begin
                        p_next = p_reg + spa_pkg::CNT_W'(1);
                    end
                    if (take_b || take_both)
                    begin
                        q_next = q_reg + spa_pkg::CNT_W'(1);
                    end
                    state_next = ST_RD;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_last_next   = 1'b1;
                    out_empty_next  = !pend_valid_reg;
                    out_exp_next    = pend_valid_reg ? pend_exp_reg : '0;
                    out_coef_next   = pend_valid_reg ? pend_coef_reg : '0;
                    pend_valid_next = 1'b0;
                    sts.done        = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            p_reg          <= '0;
            q_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            p_reg          <= p_next;
            q_reg          <= q_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_exp_reg  <= pend_exp_next;
        pend_coef_reg <= pend_coef_next;
        out_exp_reg   <= out_exp_next;
        out_coef_reg  <= out_coef_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid        = out_valid_reg;
    assign term_exponent    = out_exp_reg;
    assign term_coefficient = out_coef_reg;
    assign result_empty     = out_empty_reg;
    assign last_term        = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sparse_polynomial_adder.sv =====
// Top level of the sparse polynomial adder: load path, term memories, merge engine.
//
// Input channel (in_valid/in_stall): one beat per command. action selects load
// into the first list, load into the second list, or merge. Loads carry an
// exponent and coefficient; a load into a full list is dropped. Unused action
// codes are dropped too.
// Output channel (out_valid/out_stall): the sum terms of a merge, highest
// exponent first, the final beat flagged by last_term. If every term cancels,
// one beat with result_empty and last_term set is sent.
// A merge holds in_stall high until its last beat enters the output register,
// one merge step per pair or single term consumed; each step is a memory read
// followed by an evaluate state, since the term memories have a registered read.
// An output stall freezes the output register; the engine keeps working until
// a second term is ready, then waits. A merge clears both lists when its last
// beat enters the output register.
// Reset clears the list counts and the engine; memory contents are not cleared
// since only entries below the counts are read.
`default_nettype none

module sparse_polynomial_adder (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [1:0]                         action,
    input  wire logic [spa_pkg::EXP_W-1:0]          exponent,
    input  wire logic signed [spa_pkg::COEF_W-1:0]  coefficient,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [spa_pkg::EXP_W-1:0]               term_exponent,
    output logic signed [spa_pkg::SUM_W-1:0]        term_coefficient,
    output logic                                    result_empty,
    output logic                                    last_term
);

    logic [spa_pkg::CNT_W-1:0]  cnt_a_reg, cnt_a_next;
    logic [spa_pkg::CNT_W-1:0]  cnt_b_reg, cnt_b_next;
    logic                       in_beat;
    logic                       we_a, we_b;
    logic [spa_pkg::TERM_W-1:0] wr_data;
    logic                       rd_en;
    logic [spa_pkg::IDX_W-1:0]  rd_addr_a, rd_addr_b;
    logic [spa_pkg::TERM_W-1:0] rd_data_a, rd_data_b;
    spa_pkg::spa_ctl_t          ctl;
    spa_pkg::spa_sts_t          sts;

    assign in_stall = sts.busy;
    assign in_beat  = in_valid && !in_stall;
    assign wr_data  = {exponent, coefficient};

    // Load decode
    assign we_a = in_beat && (action == spa_pkg::ACT_LOAD_A)
                  && (cnt_a_reg < spa_pkg::CNT_W'(spa_pkg::MAX_TERMS));
    assign we_b = in_beat && (action == spa_pkg::ACT_LOAD_B)
                  && (cnt_b_reg < spa_pkg::CNT_W'(spa_pkg::MAX_TERMS));

    assign ctl.start = in_beat && (action == spa_pkg::ACT_MERGE);
    assign ctl.cnt_a = cnt_a_reg;
    assign ctl.cnt_b = cnt_b_reg;

    // List counts
    always_comb
    begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        if (sts.done)
        begin
            cnt_a_next = '0;
            cnt_b_next = '0;
        end
        else
        begin
            if (we_a)
            begin
                cnt_a_next = cnt_a_reg + spa_pkg::CNT_W'(1);
            end
            if (we_b)
            begin
                cnt_b_next = cnt_b_reg + spa_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
        end
        else
        begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
        end
    end

    // Term memories
    spa_ram #(
        .WIDTH (spa_pkg::TERM_W),
        .DEPTH (spa_pkg::MAX_TERMS)
    ) u_ram_a (
        .clk     (clk),
        .we      (we_a),
        .wr_addr (cnt_a_reg[spa_pkg::IDX_W-1:0]),
        .wr_data (wr_data),
        .re      (rd_en),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    spa_ram #(
        .WIDTH (spa_pkg::TERM_W),
        .DEPTH (spa_pkg::MAX_TERMS)
    ) u_ram_b (
        .clk     (clk),
        .we      (we_b),
        .wr_addr (cnt_b_reg[spa_pkg::IDX_W-1:0]),
        .wr_data (wr_data),
        .re      (rd_en),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    // Merge engine
    spa_merge u_merge (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .sts              (sts),
        .rd_en            (rd_en),
        .rd_addr_a        (rd_addr_a),
        .rd_addr_b        (rd_addr_b),
        .rd_data_a        (rd_data_a),
        .rd_data_b        (rd_data_b),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .term_exponent    (term_exponent),
        .term_coefficient (term_coefficient),
        .result_empty     (result_empty),
        .last_term        (last_term)
    );

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a_reg <= spa_pkg::CNT_W'(spa_pkg::MAX_TERMS))
        && (cnt_b_reg <= spa_pkg::CNT_W'(spa_pkg::MAX_TERMS)))
        else $error("term count exceeds capacity");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |=> (cnt_a_reg == '0) && (cnt_b_reg == '0))
        else $error("merge did not clear the lists");

    a_no_load_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
        (we_a || we_b) |-> !sts.busy)
        else $error("memory write during merge");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_empty) |-> last_term)
        else $error("empty result beat not marked last");

endmodule

`default_nettype wire

// ===== tb/spa_checker.sv =====
// Checker for the sparse polynomial adder: mirrors both term lists and scores every result beat.
module spa_checker
    import spa_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic                      in_stall,
    input  wire logic [1:0]                action,
    input  wire logic [EXP_W-1:0]          exponent,
    input  wire logic signed [COEF_W-1:0]  coefficient,
    input  wire logic                      out_valid,
    input  wire logic                      out_stall,
    input  wire logic [EXP_W-1:0]          term_exponent,
    input  wire logic signed [SUM_W-1:0]   term_coefficient,
    input  wire logic                      result_empty,
    input  wire logic                      last_term,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 200;

    typedef struct packed {
        logic [EXP_W-1:0]         expo;
        logic signed [COEF_W-1:0] coef;
    } poly_term_t;

    typedef struct packed {
        logic [EXP_W-1:0]        expo;
        logic signed [SUM_W-1:0] coef;
        logic                    empty;
        logic                    last;
    } sum_beat_t;

    poly_term_t first_list [MAX_TERMS];
    poly_term_t second_list [MAX_TERMS];
    int         first_fill;
    int         second_fill;
    sum_beat_t  sums_due [$];

    // sign-extend a stored coefficient to the sum width
    function automatic logic signed [SUM_W-1:0] widen(input logic signed [COEF_W-1:0] c);
        return {c[COEF_W-1], c};
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (fail_count < PRINT_CAP)
            $display("spa_checker: %s at %0t: got 0x%0h, want 0x%0h", what, $time, got, want);
        fail_count++;
    endtask

    // walk both lists highest exponent first, queue the sum beats, clear the lists
    task automatic merge_lists();
        sum_beat_t               merged [$];
        logic signed [SUM_W-1:0] total;
        int                      p = 0;
        int                      q = 0;
        while (p < first_fill && q < second_fill)
        begin
            if (first_list[p].expo == second_list[q].expo)
            begin
                total = widen(first_list[p].coef) + widen(second_list[q].coef);
                // equal exponents that cancel leave no term
                if (total != 0)
                    merged.push_back('{first_list[p].expo, total, 1'b0, 1'b0});
                p++;
                q++;
            end
            else if (first_list[p].expo < second_list[q].expo)
            begin
                merged.push_back('{second_list[q].expo, widen(second_list[q].coef), 1'b0, 1'b0});
                q++;
            end
            else
            begin
                merged.push_back('{first_list[p].expo, widen(first_list[p].coef), 1'b0, 1'b0});
                p++;
            end
        end
        for (; p < first_fill; p++)
            merged.push_back('{first_list[p].expo, widen(first_list[p].coef), 1'b0, 1'b0});
        for (; q < second_fill; q++)
            merged.push_back('{second_list[q].expo, widen(second_list[q].coef), 1'b0, 1'b0});
        first_fill = 0;
        second_fill = 0;
        // nothing survived: a single empty beat with zeroed fields
        if (merged.size() == 0)
            merged.push_back('{'0, '0, 1'b1, 1'b1});
        else
            merged[merged.size()-1].last = 1'b1;
        foreach (merged[i])
            sums_due.push_back(merged[i]);
    endtask

    // score output beats first, then fold in the input beat of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        sum_beat_t want;
        if (!rst_n)
        begin
            first_fill = 0;
            second_fill = 0;
            sums_due.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (sums_due.size() == 0)
                    flag_mismatch("result beat with nothing due", 64'(term_exponent), '0);
                else
                begin
                    want = sums_due.pop_front();
                    if (term_exponent !== want.expo)
                        flag_mismatch("term_exponent", 64'(term_exponent), 64'(want.expo));
                    if (term_coefficient !== want.coef)
                        flag_mismatch("term_coefficient", 64'(term_coefficient),
                                      64'(want.coef));
                    if (result_empty !== want.empty)
                        flag_mismatch("result_empty", 64'(result_empty), 64'(want.empty));
                    if (last_term !== want.last)
                        flag_mismatch("last_term", 64'(last_term), 64'(want.last));
                end
            end
            if (in_valid && !in_stall)
            begin
                case (action)
                    ACT_LOAD_A:
                        if (first_fill < MAX_TERMS)
                        begin
                            first_list[first_fill] = '{exponent, coefficient};
                            first_fill++;
                        end
                    ACT_LOAD_B:
                        if (second_fill < MAX_TERMS)
                        begin
                            second_list[second_fill] = '{exponent, coefficient};
                            second_fill++;
                        end
                    ACT_MERGE:
                        merge_lists();
                    default:
                        ;
                endcase
            end
            pending <= sums_due.size();
        end
    end

endmodule

// ===== tb/tb_sparse_polynomial_adder.sv =====
// Testbench top for the sparse polynomial adder: clock, reset, stimulus, stall pattern, verdict.
module tb_sparse_polynomial_adder;
    timeunit 1ns;
    timeprecision 1ps;
    import spa_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 5000;
    localparam int ITEM_TARGET = 150;
    localparam int TAIL_CYCLES = 40;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [1:0]                 action = ACT_LOAD_A;
    logic [EXP_W-1:0]           exponent = '0;
    logic signed [COEF_W-1:0]   coefficient = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [EXP_W-1:0]           term_exponent;
    logic signed [SUM_W-1:0]    term_coefficient;
    logic                       result_empty;
    logic                       last_term;
    int                         fail_count;
    int                         pending;

    int idle_cycles = 0;
    int counted = 0;
    bit burst = 1'b0;
    bit hold_req = 1'b0;

    sparse_polynomial_adder dut (.*);

    spa_checker u_checker (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    // coefficient mix: extremes, zero, small values and full random
    function automatic logic [COEF_W-1:0] coef_pick();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom;
        endcase
    endfunction

    // offer one beat after a random gap and hold it until taken
    task automatic send_beat(input logic [1:0] act, input logic [EXP_W-1:0] e,
                             input logic [COEF_W-1:0] c);
        int gap;
        int r;
        if (burst)
            gap = 0;
        else
        begin
            r = $urandom_range(0, 15);
            gap = (r < 8) ? 0 : (r < 15) ? $urandom_range(1, 3) : $urandom_range(10, 30);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        exponent    <= e;
        coefficient <= c;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // two descending term lists with shared exponents, loaded interleaved, then merged
    task automatic run_sequence(input bit pressure);
        logic [TERM_W-1:0] a_terms [$];
        logic [TERM_W-1:0] b_terms [$];
        logic [TERM_W-1:0] t;
        logic [COEF_W-1:0] c;
        int a_left;
        int b_left;
        int a_fill = 0;
        int b_fill = 0;
        int step_max;
        int e_cur;
        int pick;
        if (pressure)
            a_left = MAX_TERMS + 2;
        else if ($urandom_range(0, 5) == 0)
            a_left = $urandom_range(MAX_TERMS - 2, MAX_TERMS + 2);
        else
            a_left = $urandom_range(0, 6);
        if ($urandom_range(0, 5) == 0)
            b_left = $urandom_range(MAX_TERMS - 2, MAX_TERMS + 2);
        else
            b_left = $urandom_range(0, 6);
        case ($urandom_range(0, 2))
            0:       step_max = 1;
            1:       step_max = 8;
            default: step_max = 1500;
        endcase
        e_cur = $urandom_range((a_left + b_left) * step_max, 65535);

        // pick first only, second only or both at each exponent
        while (a_left + b_left > 0)
        begin
            pick = $urandom_range(0, 2);
            if (a_left == 0)
                pick = 1;
            else if (b_left == 0)
                pick = 0;
            c = coef_pick();
            if (pick != 1)
            begin
                a_terms.push_back({16'(e_cur), c});
                a_left--;
            end
            if (pick == 2)
            begin
                // half of the shared exponents cancel
                if ($urandom_range(0, 1) == 1)
                    c = -c;
                else
                    c = coef_pick();
            end
            if (pick != 0)
            begin
                b_terms.push_back({16'(e_cur), c});
                b_left--;
            end
            e_cur -= $urandom_range(1, step_max);
        end

        // now and then the first list goes in out of order
        if ($urandom_range(0, 7) == 0)
            foreach (a_terms[i])
                a_terms[i][TERM_W-1:COEF_W] = 16'($urandom);

        while (a_terms.size() + b_terms.size() > 0)
        begin
            if ($urandom_range(0, 11) == 0)
                send_beat(ACT_UNUSED, 16'($urandom), $urandom);
            if (b_terms.size() == 0 || (a_terms.size() != 0 && $urandom_range(0, 1) == 1))
            begin
                t = a_terms.pop_front();
                send_beat(ACT_LOAD_A, t[TERM_W-1:COEF_W], t[COEF_W-1:0]);
                if (a_fill < MAX_TERMS)
                    counted++;
                a_fill++;
            end
            else
            begin
                t = b_terms.pop_front();
                send_beat(ACT_LOAD_B, t[TERM_W-1:COEF_W], t[COEF_W-1:0]);
                if (b_fill < MAX_TERMS)
                    counted++;
                b_fill++;
            end
        end
        if (pressure)
            hold_req = 1'b1;
        send_beat(ACT_MERGE, 16'($urandom), $urandom);
        counted++;
    endtask

    // receiver: runs of accepting, short and long stalls, one long hold-off on request
    initial
    begin
        int run_len;
        int stall_len;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
            out_stall <= 1'b0;
            for (int i = 0; i < run_len && !hold_req; i++)
                @(posedge clk);
            if (!hold_req)
            begin
                stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_sparse_polynomial_adder: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // stimulus and verdict
    initial
    begin
        bit first_seq;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // merge with both lists empty
        send_beat(ACT_MERGE, 16'hFFFF, 32'hFFFF_FFFF);
        // extreme exponents and coefficients, sums at both ends of the range
        send_beat(ACT_LOAD_A, 16'hFFFF, 32'h7FFF_FFFF);
        send_beat(ACT_LOAD_A, 16'h0000, 32'h8000_0000);
        send_beat(ACT_LOAD_B, 16'hFFFF, 32'h7FFF_FFFF);
        send_beat(ACT_LOAD_B, 16'h0000, 32'h8000_0000);
        send_beat(ACT_MERGE, 16'h0000, 32'h0000_0000);
        // full cancellation
        send_beat(ACT_LOAD_A, 16'd5, 32'd7);
        send_beat(ACT_LOAD_B, 16'd5, -32'sd7);
        send_beat(ACT_MERGE, 16'd5, 32'd7);
        // zero sum drops, out-of-order load, unused code
        send_beat(ACT_LOAD_A, 16'd9, 32'd1);
        send_beat(ACT_LOAD_A, 16'd3, 32'd0);
        send_beat(ACT_LOAD_A, 16'd12, 32'hFFFF_FFFF);
        send_beat(ACT_LOAD_B, 16'd10, 32'd5);
        send_beat(ACT_LOAD_B, 16'd3, 32'd0);
        send_beat(ACT_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        send_beat(ACT_MERGE, 16'd0, 32'd0);
        // only the second list loaded
        send_beat(ACT_LOAD_B, 16'd100, -32'sd3);
        send_beat(ACT_MERGE, 16'd0, 32'd0);

        // random part; the first sequence overfills a list under a long output hold
        first_seq = 1'b1;
        while (counted < ITEM_TARGET)
        begin
            burst = ($urandom_range(0, 3) == 0);
            run_sequence(first_seq);
            first_seq = 1'b0;
        end
        in_valid <= 1'b0;

        // drain, then watch a little longer for stray beats
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_sparse_polynomial_adder: clean");
        else
            $display("tb_sparse_polynomial_adder: errors");
        $finish;
    end

endmodule
